// ===== hdl/mvr_pkg.sv =====
package mvr_pkg;

  // Word widths
  localparam int DATA_W  = 32;               // velocity width, signed
  localparam int DEPTH_W = DATA_W - 1;       // depth width, unsigned
  localparam int PROD_W  = DATA_W + DEPTH_W; // |slope| * remainder
  localparam int ACC_W   = DATA_W + 2;       // |slope| * ratio, plus quotient

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  // Input word: one column stencil
  typedef struct packed {
    logic                     mode;
    logic [DEPTH_W-1:0]       h_above;
    logic [DEPTH_W-1:0]       h_center;
    logic [DEPTH_W-1:0]       h_below;
    logic signed [DATA_W-1:0] vel_above;
    logic signed [DATA_W-1:0] vel_center;
    logic signed [DATA_W-1:0] vel_below;
  } stencil_t;

  // Output word
  typedef struct packed {
    logic signed [DATA_W-1:0] vel_face;
    status_t                  status;
  } face_t;

  // Divider operands
  typedef struct packed {
    logic [PROD_W-1:0]  num;
    logic [DEPTH_W-1:0] den;
  } div_op_t;

  // Data that rides along the divider
  typedef struct packed {
    logic [ACC_W-1:0]         a;     // |slope| * integer part of ratio
    logic signed [DATA_W-1:0] vc;    // centre velocity
    logic                     neg;   // limited velocity slope is negative
    logic                     zero;  // centre depth is zero
  } div_side_t;

endpackage

// ===== hdl/mvr_front.sv =====
module mvr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  mvr_pkg::stencil_t   in_word,
  output logic                out_valid,
  output mvr_pkg::div_op_t    op,
  output mvr_pkg::div_side_t  side
);

  localparam int DW = mvr_pkg::DATA_W;
  localparam int HW = mvr_pkg::DEPTH_W;
  localparam int PW = mvr_pkg::PROD_W;
  localparam int AW = mvr_pkg::ACC_W;

  // minmod: zero on differing signs, else the smaller magnitude
  function automatic logic signed [DW:0] minmod(input logic signed [DW:0] x,
                                                input logic signed [DW:0] y);
    logic signed [DW:0] res;
    if (x[DW] != y[DW]) res = '0;
    else if (!x[DW])    res = (x <= y) ? x : y;
    else                res = (x >= y) ? x : y;
    return res;
  endfunction

  logic v1, v2, v3, v4, v5;

  // stage 1: one-sided differences
  logic signed [HW:0] dh_lo, dh_hi;
  logic signed [DW:0] dv_lo, dv_hi;
  logic [HW-1:0]      hc1;
  logic signed [DW-1:0] vc1;
  logic               mode1, zero1;

  // stage 2: limited slopes
  logic signed [HW:0]   sh2;
  logic signed [DW:0]   sv2;
  logic [HW-1:0]        hc2;
  logic signed [DW-1:0] vc2;
  logic                 mode2, zero2;
  logic signed [DW:0]   sh_wide;

  // stage 3: face depth (one extra fraction bit) and slope magnitude
  logic [HW+1:0]        face3, h3x3;
  logic [DW-1:0]        mag3;
  logic [HW-1:0]        hc3;
  logic signed [DW-1:0] vc3;
  logic                 neg3, zero3;
  logic [DW:0]          sv_abs;
  logic [HW+1:0]        hc2_x2, face_next;

  // stage 4: face / centre as integer part and remainder
  logic [1:0]           m4;
  logic [HW-1:0]        r4, hc4;
  logic [DW-1:0]        mag4;
  logic signed [DW-1:0] vc4;
  logic                 neg4, zero4;
  logic [HW+2:0]        d1, d2, d3;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_comb begin
    sh_wide   = minmod({dh_lo[HW], dh_lo}, {dh_hi[HW], dh_hi});
    hc2_x2    = {1'b0, hc2, 1'b0};
    face_next = mode2 ? hc2_x2 + {sh2[HW], sh2} : hc2_x2 - {sh2[HW], sh2};
    sv_abs    = sv2[DW] ? -sv2 : sv2;
    d1 = {1'b0, face3} - {3'b000, hc3};
    d2 = {1'b0, face3} - {2'b00, hc3, 1'b0};
    d3 = {1'b0, face3} - {1'b0, h3x3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      dh_lo <= $signed({1'b0, in_word.h_center}) - $signed({1'b0, in_word.h_below});
      dh_hi <= $signed({1'b0, in_word.h_above}) - $signed({1'b0, in_word.h_center});
      dv_lo <= $signed({in_word.vel_center[DW-1], in_word.vel_center})
             - $signed({in_word.vel_below[DW-1], in_word.vel_below});
      dv_hi <= $signed({in_word.vel_above[DW-1], in_word.vel_above})
             - $signed({in_word.vel_center[DW-1], in_word.vel_center});
      hc1   <= in_word.h_center;
      vc1   <= in_word.vel_center;
      mode1 <= in_word.mode;
      zero1 <= (in_word.h_center == '0);
      // stage 2
      sh2   <= sh_wide[HW:0];
      sv2   <= minmod(dv_lo, dv_hi);
      hc2   <= hc1;
      vc2   <= vc1;
      mode2 <= mode1;
      zero2 <= zero1;
      // stage 3
      face3 <= face_next;
      h3x3  <= hc2_x2 + {2'b00, hc2};
      mag3  <= sv_abs[DW-1:0];
      hc3   <= hc2;
      vc3   <= vc2;
      neg3  <= sv2[DW];
      zero3 <= zero2;
      // stage 4: face lies in [hc, 3*hc]
      if (!d3[HW+2]) begin
        m4 <= 2'd3;
        r4 <= d3[HW-1:0];
      end else if (!d2[HW+2]) begin
        m4 <= 2'd2;
        r4 <= d2[HW-1:0];
      end else begin
        m4 <= 2'd1;
        r4 <= d1[HW-1:0];
      end
      mag4  <= mag3;
      hc4   <= hc3;
      vc4   <= vc3;
      neg4  <= neg3;
      zero4 <= zero3;
      // stage 5: products
      op.num    <= PW'(mag4) * PW'(r4);
      op.den    <= hc4;
      side.a    <= AW'(mag4) * AW'(m4);
      side.vc   <= vc4;
      side.neg  <= neg4;
      side.zero <= zero4;
    end
  end

  assign out_valid = v5;

endmodule

// ===== hdl/mvr_div.sv =====
module mvr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  mvr_pkg::div_op_t          op,
  input  mvr_pkg::div_side_t        side_in,
  output logic                      out_valid,
  output logic [mvr_pkg::DATA_W-1:0] quo,
  output mvr_pkg::div_side_t        side_out
);

  localparam int DW = mvr_pkg::DATA_W;
  localparam int HW = mvr_pkg::DEPTH_W;
  localparam int PW = mvr_pkg::PROD_W;

  // Restoring divider, one quotient bit per stage. The upper bits of the
  // numerator start out below the divisor, so DW stages give the quotient.
  logic                 vld  [1:DW];
  logic [HW-1:0]        rem  [1:DW];
  logic [DW-1:0]        low  [1:DW];
  logic [HW-1:0]        den  [1:DW];
  logic [DW-1:0]        qb   [1:DW];
  mvr_pkg::div_side_t   sd   [1:DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic               vld_in;
    logic [HW-1:0]      rem_in, den_in;
    logic [DW-1:0]      low_in, q_in;
    mvr_pkg::div_side_t sd_in;
    logic [HW:0]        trial;
    logic [HW+1:0]      diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = op.num[PW-1:DW];
      assign low_in = op.num[DW-1:0];
      assign den_in = op.den;
      assign q_in   = '0;
      assign sd_in  = side_in;
    end else begin : g_rest
      assign vld_in = vld[k];
      assign rem_in = rem[k];
      assign low_in = low[k];
      assign den_in = den[k];
      assign q_in   = qb[k];
      assign sd_in  = sd[k];
    end

    // trial subtract with the next numerator bit
    always_comb begin
      trial = {rem_in, low_in[DW-1-k]};
      diff  = {1'b0, trial} - {2'b00, den_in};
      ge    = !diff[HW+1];
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[HW-1:0] : trial[HW-1:0];
        low[k+1] <= low_in;
        den[k+1] <= den_in;
        qb[k+1]  <= {q_in[DW-2:0], ge};
        sd[k+1]  <= sd_in;
      end
    end
  end

  assign out_valid = vld[DW];
  assign quo       = qb[DW];
  assign side_out  = sd[DW];

endmodule

// ===== hdl/mvr_back.sv =====
module mvr_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [mvr_pkg::DATA_W-1:0] quo,
  input  mvr_pkg::div_side_t         side,
  output logic                       en,
  output logic                       face_valid,
  input  logic                       face_ready,
  output mvr_pkg::face_t             face
);

  localparam int DW = mvr_pkg::DATA_W;
  localparam int AW = mvr_pkg::ACC_W;
  localparam logic signed [DW-1:0] VelMax = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VelMin = {1'b1, {(DW-1){1'b0}}};

  // final correction term q = (|s|*m + floor(|s|*r/hc)) / 4
  logic                 vb;
  logic [DW-1:0]        qq;
  logic signed [DW-1:0] vcb;
  logic                 negb, zerob;
  logic [AW-1:0]        sum;

  // result and status
  logic signed [DW+1:0] res;
  mvr_pkg::face_t       word_new;

  // output register and skid entry
  logic           skid_valid;
  mvr_pkg::face_t skid;
  logic           take, new_v, load_out, load_skid;
  logic           face_valid_next, skid_valid_next;

  assign sum = side.a + AW'(quo);

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qq    <= sum[DW+1:2];
      vcb   <= side.vc;
      negb  <= side.neg;
      zerob <= side.zero;
    end
  end

  // apply correction, saturate; a zero centre depth gives 0
  always_comb begin
    res = negb ? {{2{vcb[DW-1]}}, vcb} + $signed({2'b00, qq})
               : {{2{vcb[DW-1]}}, vcb} - $signed({2'b00, qq});
    if (zerob) begin
      word_new.vel_face = '0;
      word_new.status   = mvr_pkg::STATUS_ZERO;
    end else if (res[DW+1:DW-1] != 3'b000 && res[DW+1:DW-1] != 3'b111) begin
      word_new.vel_face = res[DW+1] ? VelMin : VelMax;
      word_new.status   = mvr_pkg::STATUS_SAT;
    end else begin
      word_new.vel_face = res[DW-1:0];
      word_new.status   = mvr_pkg::STATUS_OK;
    end
  end

  // output buffer control: the pipeline freezes only while the skid is full
  always_comb begin
    en              = !skid_valid;
    take            = !face_valid || face_ready;
    new_v           = en && vb;
    load_skid       = !take && new_v;
    load_out        = take && (skid_valid || new_v);
    face_valid_next = take ? (skid_valid || new_v) : 1'b1;
    skid_valid_next = skid_valid ? !take : load_skid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      face_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      face_valid <= face_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) face <= skid_valid ? skid : word_new;
    if (load_skid) skid <= word_new;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> face_valid)
    else $error("skid holds a word while output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(face_valid && !face_ready))
    else $error("skid filled without an output stall");

  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    face_valid && face.status == mvr_pkg::STATUS_ZERO |-> face.vel_face == '0)
    else $error("zero depth result is not zero");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    face_valid && face.status == mvr_pkg::STATUS_SAT |->
      face.vel_face == VelMax || face.vel_face == VelMin)
    else $error("saturated result is not a limit value");

endmodule

// ===== hdl/minmod_velocity_reconstruction.sv =====
// MUSCL face-velocity reconstruction with minmod limiting, one column stencil
// per word. Accepts one stencil word every clock while stencil_ready is high
// and returns one face word per stencil, in order, through five front stages
// (differences, minmod, face depth, ratio split, products), a 32-stage
// restoring divider that forms |slope|*rem/h_center one quotient bit per
// stage and sets most of the latency, one stage for the correction sum, and
// the output register. A skid entry behind the output register absorbs one
// word of backpressure; stencil_ready drops only while it is occupied. A
// zero centre depth gives 0 with status 2; an out-of-range result
// saturates with status 1.
module minmod_velocity_reconstruction (
  input  logic              clk,
  input  logic              rst,
  input  logic              stencil_valid,
  output logic              stencil_ready,
  input  mvr_pkg::stencil_t stencil,
  output logic              face_valid,
  input  logic              face_ready,
  output mvr_pkg::face_t    face
);

  logic                       en;
  logic                       front_valid, div_valid;
  mvr_pkg::div_op_t           op;
  mvr_pkg::div_side_t         front_side, div_side;
  logic [mvr_pkg::DATA_W-1:0] quo;

  assign stencil_ready = en;

  mvr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (stencil_valid),
    .in_word   (stencil),
    .out_valid (front_valid),
    .op        (op),
    .side      (front_side)
  );

  mvr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .op        (op),
    .side_in   (front_side),
    .out_valid (div_valid),
    .quo       (quo),
    .side_out  (div_side)
  );

  mvr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (div_valid),
    .quo        (quo),
    .side       (div_side),
    .en         (en),
    .face_valid (face_valid),
    .face_ready (face_ready),
    .face       (face)
  );

endmodule
